@@ design/lsu_pkg.sv @@
// ----------------------------------------------------------------------------
// lsu_pkg: shared types and constants for the indexed list store
// Sizes of the cell row and the read tree, command codes, result status
// codes and the command structs handed to every cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lsu_pkg;

    // number of cells in the row, one element each
    localparam int CAPACITY = 1024;

    // item field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 12;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // internal widths
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // read tree: each registered level merges up to 2**TREE_RADIX_LOG nodes
    localparam int TREE_RADIX_LOG = 5;

    // nodes on one level of the read tree, level 0 being the cells
    function automatic int level_nodes(input int level);
        int n;
        n = CAPACITY;
        for (int l = 0; l < level; l++) begin
            n = (n + (1 << TREE_RADIX_LOG) - 1) >> TREE_RADIX_LOG;
        end
        return n;
    endfunction

    // registered levels needed to reach a single node
    function automatic int tree_levels();
        int n;
        int l;
        n = CAPACITY;
        l = 0;
        while (n > 1) begin
            n = (n + (1 << TREE_RADIX_LOG) - 1) >> TREE_RADIX_LOG;
            l++;
        end
        return l;
    endfunction

    // first slot of a level in the flat node store, level 1 at slot 0
    function automatic int level_offset(input int level);
        int off;
        off = 0;
        for (int l = 1; l < level; l++) begin
            off += level_nodes(l);
        end
        return off;
    endfunction

    localparam int TREE_LEVELS = tree_levels();
    localparam int TREE_NODES  = level_offset(TREE_LEVELS + 1);
    localparam int WAIT_W      = $clog2(TREE_LEVELS + 2);

    // command codes
    localparam logic [OP_W-1:0] OP_GET      = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT   = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // update broadcast to all cells on the accepting edge
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [IDX_W-1:0]  at;
        logic [DATA_W-1:0] value;
    } lsu_cmd_t;

    // read select held while a result is being gathered
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] at;
    } lsu_rd_t;

endpackage

`default_nettype wire

@@ design/lsu_cell.sv @@
// ----------------------------------------------------------------------------
// lsu_cell: one element slot of the list
// Holds one value, loads the new value on an insert at its index, takes its
// left neighbour's value on an insert below it, its right neighbour's on a
// delete at or below it, and drives its value to the read tree when selected.
// ----------------------------------------------------------------------------
`default_nettype none

module lsu_cell
    import lsu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [IDX_W-1:0]  cell_idx,
    input  wire lsu_cmd_t          cmd,
    input  wire lsu_rd_t           rd,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] cell_data,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] data_reg;

    // shift or load on insert and delete
    always_ff @(posedge aclk) begin
        if (cmd.ins) begin
            if (cell_idx > cmd.at) begin
                data_reg <= left_data;
            end else if (cell_idx == cmd.at) begin
                data_reg <= cmd.value;
            end
        end else if (cmd.del) begin
            if (cell_idx >= cmd.at) begin
                data_reg <= right_data;
            end
        end
    end

    assign cell_data = data_reg;

    // masked value for the or tree
    assign rd_data = (rd.en && (cell_idx == rd.at)) ? data_reg : '0;

endmodule

`default_nettype wire

@@ design/lsu_read_tree.sv @@
// ----------------------------------------------------------------------------
// lsu_read_tree: registered or tree over the cell read outputs
// At most one cell drives a nonzero value, so each level merges groups of
// nodes with a wide or and registers the merged value.
// ----------------------------------------------------------------------------
`default_nettype none

module lsu_read_tree
    import lsu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [DATA_W-1:0] leaf_data [CAPACITY],
    output logic      [DATA_W-1:0] root_data
);

    localparam int RADIX = 1 << TREE_RADIX_LOG;

    // all levels above the leaves, level by level
    logic [DATA_W-1:0] node_reg [TREE_NODES];

    for (genvar l = 1; l <= TREE_LEVELS; l++) begin : g_level
        localparam int N    = level_nodes(l);
        localparam int NP   = level_nodes(l - 1);
        localparam int OFF  = level_offset(l);
        localparam int OFFP = level_offset(l - 1);

        for (genvar k = 0; k < N; k++) begin : g_node
            logic [DATA_W-1:0] merged;

            // merge one group of children
            if (l == 1) begin : g_leaf
                always_comb begin
                    merged = '0;
                    for (int c = 0; c < RADIX; c++) begin
                        if (k * RADIX + c < NP) begin
                            merged = merged | leaf_data[k * RADIX + c];
                        end
                    end
                end
            end else begin : g_inner
                always_comb begin
                    merged = '0;
                    for (int c = 0; c < RADIX; c++) begin
                        if (k * RADIX + c < NP) begin
                            merged = merged | node_reg[OFFP + k * RADIX + c];
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                node_reg[OFF + k] <= merged;
            end
        end
    end

    assign root_data = node_reg[level_offset(TREE_LEVELS)];

endmodule

`default_nettype wire

@@ design/indexed_list_store_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store_unit: bounded ordered list of signed 32-bit values
// A row of CAPACITY cells holds the list; an insert or delete shifts the
// upper cells in parallel on the accepting edge, gets read via an or tree.
// ----------------------------------------------------------------------------
// Usage:
//   The command channel (s_) carries an opcode, a signed position and a
//   value; each command gives exactly one result item on the m_ channel
//   with the read value, a status code and the element count afterwards.
//   Both channels use valid/ready, an item moves when both are high.
//   The read select is registered on acceptance; the registered read tree,
//   whose registered levels each merge 32 nodes, gathers the element, and
//   the result is loaded into the output register once the root settles.
//   Only one command is in flight at a time: s_ready stays low from
//   acceptance until its result is loaded into the output register.
//   A new command may be accepted while the previous result still waits
//   in the output register; if the receiver stalls, that result is held
//   and the next result waits until the output register is free.
//   Reset clears the element count and all handshake state; stored
//   values are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_unit
    import lsu_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic        [OP_W-1:0]     s_opcode,
    input  wire logic signed [POS_W-1:0]    s_position,
    input  wire logic signed [DATA_W-1:0]   s_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed      [DATA_W-1:0]   m_read_value,
    output logic             [STATUS_W-1:0] m_status,
    output logic             [COUNT_W-1:0]  m_count
);

    logic                accept;
    logic                out_load;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                busy_reg;
    logic [WAIT_W-1:0]   wait_reg;
    lsu_rd_t             rd_reg;
    lsu_rd_t             rd_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_read_value_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic                pos_neg;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    at_ext;
    logic                in_range;
    logic                full;
    logic                ins_ok;
    logic                del_ok;
    logic                rd_ok;
    lsu_cmd_t            cmd;
    logic [CNT_W+COUNT_W-1:0] count_wide;

    logic [DATA_W-1:0]   cell_data  [CAPACITY];
    logic [DATA_W-1:0]   left_data  [CAPACITY];
    logic [DATA_W-1:0]   right_data [CAPACITY];
    logic [DATA_W-1:0]   rd_data    [CAPACITY];
    logic [DATA_W-1:0]   root_data;

    // no item is taken while reset is held
    assign accept   = s_valid && s_ready;
    assign s_ready  = aresetn && !busy_reg;
    assign out_load = busy_reg && (wait_reg == WAIT_W'(1)) && (!m_valid_reg || m_ready);

    // position and count compared at a common width
    assign pos_neg  = s_position[POS_W-1];
    assign pos_ext  = {{(CMP_W-POS_W){1'b0}}, s_position};
    assign cnt_ext  = {{(CMP_W-CNT_W){1'b0}}, count_reg};
    assign in_range = !pos_neg && (pos_ext < cnt_ext);
    assign full     = (count_reg == CNT_W'(CAPACITY));

    // command decode, range and capacity checks
    always_comb begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        rd_ok       = 1'b0;
        at_ext      = '0;
        status_next = STATUS_DONE;
        unique case (s_opcode)
            OP_GET: begin
                if (in_range) begin
                    rd_ok  = 1'b1;
                    at_ext = pos_ext;
                end else begin
                    status_next = STATUS_BAD_INDEX;
                end
            end
            OP_INS_HEAD: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            OP_INS_TAIL: begin
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ins_ok = 1'b1;
                    at_ext = cnt_ext;
                end
            end
            OP_INS_AT: begin
                if (!pos_neg && (pos_ext > cnt_ext)) begin
                    status_next = STATUS_BAD_INDEX;
                end else if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ins_ok = 1'b1;
                    at_ext = pos_neg ? '0 : pos_ext;
                end
            end
            OP_DELETE: begin
                if (in_range) begin
                    del_ok = 1'b1;
                    at_ext = pos_ext;
                end else begin
                    status_next = STATUS_BAD_INDEX;
                end
            end
            default: begin
            end
        endcase
    end

    // broadcast to the cells on the accepting edge
    assign cmd.ins   = accept && ins_ok;
    assign cmd.del   = accept && del_ok;
    assign cmd.at    = at_ext[IDX_W-1:0];
    assign cmd.value = s_value;

    assign rd_next.en = rd_ok;
    assign rd_next.at = at_ext[IDX_W-1:0];

    // element count after this command
    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // control: count, busy flag, tree wait counter, read select and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            wait_reg    <= '0;
            rd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                busy_reg <= 1'b1;
                wait_reg <= WAIT_W'(TREE_LEVELS + 1);
                rd_reg   <= rd_next;
            end else if (out_load) begin
                busy_reg <= 1'b0;
            end else if (busy_reg && (wait_reg != WAIT_W'(1))) begin
                wait_reg <= wait_reg - WAIT_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
        if (out_load) begin
            m_read_value_reg <= rd_reg.en ? root_data : '1;
            m_status_reg     <= status_reg;
            m_count_reg      <= count_wide[COUNT_W-1:0];
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, count_reg};

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;

    // row of cells, each linked to its neighbours, with zero beyond either end
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_data[i] = '0;
        end else begin : g_left
            assign left_data[i] = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_data[i] = '0;
        end else begin : g_right
            assign right_data[i] = cell_data[i+1];
        end

        lsu_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_W'(i)),
            .cmd        (cmd),
            .rd         (rd_reg),
            .left_data  (left_data[i]),
            .right_data (right_data[i]),
            .cell_data  (cell_data[i]),
            .rd_data    (rd_data[i])
        );
    end

    // gather the selected element
    lsu_read_tree u_read_tree (
        .aclk      (aclk),
        .leaf_data (rd_data),
        .root_data (root_data)
    );

endmodule

`default_nettype wire

@@ design/lsu_checker.sv @@
// ----------------------------------------------------------------------------
// lsu_checker: port-level checks for the indexed list store
// Watches the command and result channels of the top level; bound to it
// below.
// ----------------------------------------------------------------------------
`default_nettype none

module lsu_checker
    import lsu_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [DATA_W-1:0]   m_read_value,
    input wire logic [STATUS_W-1:0] m_status,
    input wire logic [COUNT_W-1:0]  m_count
);

    // one command in flight: no second item on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted while another is in flight");

    // a refused command, with a status other than done, reads back minus one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_DONE)) |-> (m_read_value == '1))
        else $error("ignored command returned a value");

    // full status only with the list at capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STATUS_FULL)) |-> (m_count == COUNT_W'(CAPACITY)))
        else $error("full status with list below capacity");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value)
            && $stable(m_status) && $stable(m_count)))
        else $error("stalled result changed");

endmodule

bind indexed_list_store_unit lsu_checker u_lsu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value),
    .m_status     (m_status),
    .m_count      (m_count)
);

`default_nettype wire

@@ test/indexed_list_store_unit_tb.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store_unit_tb: self-checking testbench for the list store
// Sends commands on the s_ channel and checks each result item on the m_
// channel against a queue-based copy of the list. The run has four parts:
// a table of corner cases, a fill to capacity with inserts on the full
// list, a drain with no idling, and random traffic. Both sides idle at
// random.
// ----------------------------------------------------------------------------
module indexed_list_store_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsu_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 800;
    localparam int IDLE_PCT      = 35;
    localparam int SETTLE_CYCLES = 4 * (TREE_LEVELS + 2);

    localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

    // opcodes the block leaves unused
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [POS_W-1:0]  pos;
        logic signed [DATA_W-1:0] value;
        logic                     typed;
        list_result_t             res;
    } cmd_row_t;

    // corner cases; rows with typed clear are checked against the list copy
    localparam cmd_row_t CORNER_ROWS [25] = '{
        '{OP_GET,      12'sd0,    32'sd0,           1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd0}},
        '{OP_DELETE,   12'sd0,    32'sd0,           1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd0}},
        '{OP_INS_AT,   12'sd1,    32'sh1234_5678,   1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd0}},
        '{OP_INS_HEAD, 12'sd0,    32'sh7fff_ffff,   1'b1,
          '{NO_VALUE, STATUS_DONE, 11'd1}},
        '{OP_INS_TAIL, 12'sd0,    32'sh8000_0000,   1'b1,
          '{NO_VALUE, STATUS_DONE, 11'd2}},
        '{OP_INS_AT,   12'sh800,  32'sd0,           1'b1,
          '{NO_VALUE, STATUS_DONE, 11'd3}},
        '{OP_INS_AT,   12'sd3,    32'shffff_ffff,   1'b1,
          '{NO_VALUE, STATUS_DONE, 11'd4}},
        '{OP_INS_AT,   12'sd2047, 32'sh5555_5555,   1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd4}},
        '{OP_INS_AT,   12'sd5,    32'shaaaa_aaaa,   1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd4}},
        '{OP_GET,      12'sd0,    32'sd0,           1'b0, '0},
        '{OP_GET,      12'sd1,    32'sd0,           1'b0, '0},
        '{OP_GET,      12'sd2,    32'sd0,           1'b0, '0},
        '{OP_GET,      12'sd3,    32'sd0,           1'b0, '0},
        '{OP_GET,      12'sd4,    32'sd0,           1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd4}},
        '{OP_GET,      12'shfff,  32'sd0,           1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd4}},
        '{OP_GET,      12'sh800,  32'sd0,           1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd4}},
        '{OP_GET,      12'sd2047, 32'sd0,           1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd4}},
        '{OP_RSVD5,    12'shfff,  32'shffff_ffff,   1'b1,
          '{NO_VALUE, STATUS_DONE, 11'd4}},
        '{OP_RSVD6,    12'shfff,  32'shffff_ffff,   1'b1,
          '{NO_VALUE, STATUS_DONE, 11'd4}},
        '{OP_RSVD7,    12'shfff,  32'shffff_ffff,   1'b1,
          '{NO_VALUE, STATUS_DONE, 11'd4}},
        '{OP_DELETE,   12'shfff,  32'sd0,           1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd4}},
        '{OP_DELETE,   12'sd4,    32'sd0,           1'b1,
          '{NO_VALUE, STATUS_BAD_INDEX, 11'd4}},
        '{OP_DELETE,   12'sd3,    32'sd0,           1'b1,
          '{NO_VALUE, STATUS_DONE, 11'd3}},
        '{OP_DELETE,   12'sd0,    32'sd0,           1'b0, '0},
        '{OP_GET,      12'sd0,    32'sd0,           1'b0, '0}
    };

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_opcode = '0;
    logic signed [POS_W-1:0]   s_position = '0;
    logic signed [DATA_W-1:0]  s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [DATA_W-1:0]  m_read_value;
    logic [STATUS_W-1:0]       m_status;
    logic [COUNT_W-1:0]        m_count;

    // list contents as the block should hold them, head first
    logic signed [DATA_W-1:0]  held_values [$];
    // results owed by the block, oldest first
    list_result_t              pending_results [$];

    bit                        no_idle = 1'b0;
    int                        n_errors = 0;
    int unsigned               cycle_count = 0;

    indexed_list_store_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count)
    );

    // clock, 8 ns period
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // apply one command to the list copy and work out its result
    function automatic list_result_t apply_cmd(input logic [OP_W-1:0] op,
                                               input logic signed [POS_W-1:0] pos,
                                               input logic signed [DATA_W-1:0] value);
        list_result_t r;
        int           p;
        int           n;
        bit           in_range;
        p = pos;
        n = held_values.size();
        in_range = (p >= 0) && (p < n);
        r.read_value = NO_VALUE;
        r.status = STATUS_DONE;
        case (op)
            OP_GET: begin
                if (in_range) begin
                    r.read_value = held_values[p];
                end else begin
                    r.status = STATUS_BAD_INDEX;
                end
            end
            OP_INS_HEAD, OP_INS_TAIL: begin
                if (n >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else if (op == OP_INS_HEAD) begin
                    held_values.push_front(value);
                end else begin
                    held_values.push_back(value);
                end
            end
            OP_INS_AT: begin
                // bad index takes precedence over full
                if (p > n) begin
                    r.status = STATUS_BAD_INDEX;
                end else if (n >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else if (p < 0) begin
                    held_values.push_front(value);
                end else begin
                    held_values.insert(p, value);
                end
            end
            OP_DELETE: begin
                if (in_range) begin
                    held_values.delete(p);
                end else begin
                    r.status = STATUS_BAD_INDEX;
                end
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(held_values.size());
        return r;
    endfunction

    // random position holding an element, 0 on an empty list
    function automatic int held_position();
        if (held_values.size() == 0) begin
            return 0;
        end
        return $urandom_range(held_values.size() - 1);
    endfunction

    // offer one item after a random gap and record its expected result
    task automatic send_cmd(input logic [OP_W-1:0] op, input int pos,
                            input logic signed [DATA_W-1:0] value,
                            input bit typed = 1'b0, input list_result_t typed_res = '0);
        list_result_t predicted;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_opcode   <= op;
        s_position <= POS_W'(pos);
        s_value    <= value;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = apply_cmd(op, POS_W'(pos), value);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // hold off the sender until every result has come back
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // stimulus
    initial begin : stimulus
        int roll;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner cases from the table
        foreach (CORNER_ROWS[i]) begin
            send_cmd(CORNER_ROWS[i].op, CORNER_ROWS[i].pos, CORNER_ROWS[i].value,
                     CORNER_ROWS[i].typed, CORNER_ROWS[i].res);
        end
        wait_for_results();

        // fill to capacity with a mix of inserts and reads
        while (held_values.size() < CAPACITY) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
                send_cmd(OP_GET, held_position(), $urandom);
            end else if (roll < 45) begin
                send_cmd(OP_INS_HEAD, $urandom_range(4095), $urandom);
            end else if (roll < 70) begin
                send_cmd(OP_INS_TAIL, $urandom_range(4095), $urandom);
            end else if (roll < 90) begin
                send_cmd(OP_INS_AT, $urandom_range(held_values.size()), $urandom);
            end else begin
                send_cmd(OP_INS_AT, -int'($urandom_range(2048, 1)), $urandom);
            end
        end

        // full list: inserts refused, bad index still checked first
        send_cmd(OP_INS_HEAD, 0, $urandom);
        send_cmd(OP_INS_TAIL, 0, $urandom);
        send_cmd(OP_INS_AT, 0, $urandom);
        send_cmd(OP_INS_AT, -7, $urandom);
        send_cmd(OP_INS_AT, CAPACITY, $urandom);
        send_cmd(OP_INS_AT, CAPACITY + 1, $urandom);
        send_cmd(OP_GET, CAPACITY - 1, $urandom);
        send_cmd(OP_GET, CAPACITY, $urandom);
        send_cmd(OP_DELETE, CAPACITY, $urandom);

        // drain back to a short list, no idling on either side
        no_idle = 1'b1;
        while (held_values.size() > 4) begin
            if ($urandom_range(99) < 25) begin
                send_cmd(OP_GET, held_position(), $urandom);
            end else begin
                send_cmd(OP_DELETE, held_position(), $urandom);
            end
        end
        no_idle = 1'b0;

        // random traffic, mostly well-formed with some noise
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                wait_for_results();
            end
            roll = $urandom_range(99);
            if (roll < 28) begin
                send_cmd(OP_GET, held_position(), $urandom);
            end else if (roll < 40) begin
                send_cmd(OP_INS_HEAD, $urandom_range(4095), $urandom);
            end else if (roll < 52) begin
                send_cmd(OP_INS_TAIL, $urandom_range(4095), $urandom);
            end else if (roll < 66) begin
                send_cmd(OP_INS_AT, $urandom_range(held_values.size()), $urandom);
            end else if (roll < 90) begin
                send_cmd(OP_DELETE, held_position(), $urandom);
            end else begin
                send_cmd(OP_W'($urandom), $urandom_range(4095), $urandom);
            end
        end

        // let the last results drain, then a short settle
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("indexed_list_store_unit_tb: done, clean");
        end else begin
            $display("indexed_list_store_unit_tb: done, errors");
        end
        $finish;
    end

    // receiver stalls at random
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin : check_results
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: read_value %0d status %0d count %0d",
                       m_read_value, m_status, m_count);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_read_value !== want.read_value) begin
                    $error("m_read_value: expected %0d, got %0d", want.read_value, m_read_value);
                    n_errors++;
                end
                if (m_status !== want.status) begin
                    $error("m_status: expected %0d, got %0d", want.status, m_status);
                    n_errors++;
                end
                if (m_count !== want.count) begin
                    $error("m_count: expected %0d, got %0d", want.count, m_count);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("indexed_list_store_unit_tb: done, errors");
            $finish;
        end
    end

endmodule

@@ sim.f @@
design/lsu_pkg.sv
design/lsu_cell.sv
design/lsu_read_tree.sv
design/indexed_list_store_unit.sv
design/lsu_checker.sv
test/indexed_list_store_unit_tb.sv
